FILE: hw/rtl/pls_pkg.sv
// Package with shared constants, codes and the control bundle of the positional list.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;
  localparam int COUNT_W      = 7;

  // Command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_SORT   = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Write data sources.
  localparam logic [1:0] SRC_RDATA = 2'd0;
  localparam logic [1:0] SRC_VALUE = 2'd1;
  localparam logic [1:0] SRC_MIN   = 2'd2;
  localparam logic [1:0] SRC_HOLD  = 2'd3;

  // Hold register operations.
  localparam logic [1:0] HOLD_KEEP  = 2'd0;
  localparam logic [1:0] HOLD_RDATA = 2'd1;
  localparam logic [1:0] HOLD_MAX   = 2'd2;

  // Entry count operations.
  localparam logic [1:0] CNT_KEEP = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  // Result value selection.
  localparam logic VAL_ZERO = 1'b0;
  localparam logic VAL_HOLD = 1'b1;

  typedef struct packed {
    logic       val_ld;
    logic       rd_en;
    logic       wr_en;
    logic [1:0] wr_src;
    logic [1:0] hold_op;
    logic [1:0] cnt_op;
    logic       res_en;
    logic [1:0] res_status;
    logic       res_val;
  } pls_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/positional_list_with_sort.sv
// A rejected item or a sort of one entry gives its result the cycle after start.
// Read fetches one entry; insert and delete shift the tail of the list one entry per cycle
// through memory, and insert writes only the new value when nothing moves.
// Sort of n entries is a bubble pass per length m = n..2.
// One item at a time (busy high while working); the result strobe cannot be stalled.
// Synchronous reset empties the list; the entry memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_with_sort
  import pls_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               cmd,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          done,
  output logic      [1:0]               status,
  output logic signed [DATA_W-1:0]      value_out,
  output logic      [COUNT_W-1:0]       count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  pls_ctl_t      ctl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] cnt;

  pls_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .position(position),
    .cnt     (cnt),
    .busy    (busy),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr)
  );

  pls_dp #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .value_in (value),
    .cnt      (cnt),
    .done     (done),
    .status   (status),
    .value_out(value_out),
    .count    (count)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/pls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pls_dp.sv
// Datapath of the positional list: entry memory, count, hold register and result registers.
`timescale 1ns / 1ps
`default_nettype none

module pls_dp
  import pls_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int AW = $clog2(CAPACITY),
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire pls_ctl_t                  ctl,
  input  wire logic [AW-1:0]             rd_addr,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic signed [DATA_W-1:0]  value_in,
  output logic      [CW-1:0]             cnt,
  output logic                           done,
  output logic      [1:0]                status,
  output logic signed [DATA_W-1:0]       value_out,
  output logic      [COUNT_W-1:0]        count
);

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] hold;
  logic signed [DATA_W-1:0] hold_next;
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] wdata;
  logic signed [DATA_W-1:0] min_v;
  logic signed [DATA_W-1:0] max_v;
  logic                     gt;
  logic [CW-1:0]            cnt_next;
  logic [CW+COUNT_W-1:0]    cnt_wide;

  pls_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.wr_en),
    .waddr(wr_addr),
    .wdata(wdata),
    .re   (ctl.rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // One compare-exchange step of a bubble pass: the larger value travels on.
  assign gt    = hold > rdata;
  assign min_v = gt ? rdata : hold;
  assign max_v = gt ? hold : rdata;

  always_comb begin
    case (ctl.wr_src)
      SRC_RDATA: wdata = rdata;
      SRC_VALUE: wdata = val_r;
      SRC_MIN:   wdata = min_v;
      SRC_HOLD:  wdata = hold;
      default:   wdata = rdata;
    endcase
  end

  always_comb begin
    case (ctl.hold_op)
      HOLD_KEEP:  hold_next = hold;
      HOLD_RDATA: hold_next = rdata;
      HOLD_MAX:   hold_next = max_v;
      default:    hold_next = hold;
    endcase
  end

  always_comb begin
    case (ctl.cnt_op)
      CNT_KEEP: cnt_next = cnt;
      CNT_INC:  cnt_next = cnt + CW'(1);
      CNT_DEC:  cnt_next = cnt - CW'(1);
      default:  cnt_next = cnt;
    endcase
  end

  assign cnt_wide = (CW + COUNT_W)'(cnt_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      done <= ctl.res_en;
    end
  end

  always_ff @(posedge clk) begin
    hold <= hold_next;
    if (ctl.val_ld) begin
      val_r <= value_in;
    end
    if (ctl.res_en) begin
      status    <= ctl.res_status;
      value_out <= (ctl.res_val == VAL_HOLD) ? hold_next : '0;
      count     <= cnt_wide[COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pls_ctrl.sv
// Controller of the positional list: command checks and the shift and sort sequencer.
`timescale 1ns / 1ps
`default_nettype none

module pls_ctrl
  import pls_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int AW = $clog2(CAPACITY),
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       cmd,
  input  wire logic [POS_W-1:0] position,
  input  wire logic [CW-1:0]    cnt,
  output logic                  busy,
  output pls_ctl_t              ctl,
  output logic      [AW-1:0]    rd_addr,
  output logic      [AW-1:0]    wr_addr
);

  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic          state, state_next;
  logic [1:0]    op, op_next;
  logic [AW-1:0] idx, idx_next;
  logic [CW-1:0] rem, rem_next;
  logic          first, first_next;
  logic          pv, pv_next;
  logic          pfirst, pfirst_next;
  logic [AW-1:0] paddr, paddr_next;
  logic [AW-1:0] pos_r, pos_r_next;
  logic [CW-1:0] slen, slen_next;

  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] n_x;
  logic            pos_ok_ins;
  logic            pos_ok_rd;
  logic            full;
  logic [AW-1:0]   pos_m1;
  logic [CW-1:0]   tail_len;
  logic            issue;

  assign pos_x      = CMPW'(position);
  assign n_x        = CMPW'(cnt);
  assign pos_ok_ins = (position != '0) && (pos_x <= n_x + CMPW'(1));
  assign pos_ok_rd  = (position != '0) && (pos_x <= n_x);
  assign full       = n_x >= CMPW'(CAPACITY);
  assign pos_m1     = AW'(pos_x - CMPW'(1));
  assign tail_len   = CW'(n_x - pos_x + CMPW'(1));
  assign issue      = rem != '0;
  assign busy       = state != S_IDLE;

  always_comb begin
    state_next  = state;
    op_next     = op;
    idx_next    = idx;
    rem_next    = rem;
    first_next  = first;
    pv_next     = 1'b0;
    pfirst_next = 1'b0;
    paddr_next  = paddr;
    pos_r_next  = pos_r;
    slen_next   = slen;
    ctl         = '0;
    rd_addr     = idx;
    wr_addr     = paddr;

    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.val_ld = 1'b1;
          op_next    = cmd;
          first_next = 1'b1;
          case (cmd)
            CMD_INSERT: begin
              if (!pos_ok_ins) begin
                ctl.res_en     = 1'b1;
                ctl.res_status = ST_INVALID;
              end else if (full) begin
                ctl.res_en     = 1'b1;
                ctl.res_status = ST_FULL;
              end else begin
                // Entries from the end down to the position move up by one.
                idx_next   = AW'(n_x - CMPW'(1));
                rem_next   = tail_len;
                pos_r_next = pos_m1;
                state_next = S_RUN;
              end
            end
            CMD_DELETE, CMD_READ: begin
              if (!pos_ok_rd) begin
                ctl.res_en     = 1'b1;
                ctl.res_status = ST_INVALID;
              end else begin
                idx_next   = pos_m1;
                rem_next   = (cmd == CMD_DELETE) ? tail_len : CW'(1);
                state_next = S_RUN;
              end
            end
            CMD_SORT: begin
              if (cnt == '0) begin
                ctl.res_en     = 1'b1;
                ctl.res_status = ST_INVALID;
              end else if (cnt == CW'(1)) begin
                ctl.res_en     = 1'b1;
                ctl.res_status = ST_OK;
              end else begin
                idx_next   = '0;
                rem_next   = cnt;
                slen_next  = cnt;
                state_next = S_RUN;
              end
            end
            default: begin
              ctl.res_en     = 1'b1;
              ctl.res_status = ST_INVALID;
            end
          endcase
        end
      end

      S_RUN: begin
        // Issue one read per cycle; the read data is registered and comes back in the next cycle.
        ctl.rd_en   = issue;
        pv_next     = issue;
        pfirst_next = issue & first;
        paddr_next  = idx;
        if (issue) begin
          rem_next   = rem - CW'(1);
          idx_next   = (op == CMD_INSERT) ? idx - AW'(1) : idx + AW'(1);
          first_next = 1'b0;
        end

        if (pv) begin
          case (op)
            CMD_READ: begin
              ctl.hold_op = HOLD_RDATA;
            end
            CMD_DELETE: begin
              if (pfirst) begin
                ctl.hold_op = HOLD_RDATA;
              end else begin
                ctl.wr_en  = 1'b1;
                ctl.wr_src = SRC_RDATA;
                wr_addr    = paddr - AW'(1);
              end
            end
            CMD_INSERT: begin
              ctl.wr_en  = 1'b1;
              ctl.wr_src = SRC_RDATA;
              wr_addr    = paddr + AW'(1);
            end
            CMD_SORT: begin
              if (pfirst) begin
                ctl.hold_op = HOLD_RDATA;
              end else begin
                ctl.wr_en   = 1'b1;
                ctl.wr_src  = SRC_MIN;
                ctl.hold_op = HOLD_MAX;
                wr_addr     = paddr - AW'(1);
              end
            end
            default: begin
              ctl.hold_op = HOLD_KEEP;
            end
          endcase
        end

        if (!issue && !pv) begin
          case (op)
            CMD_READ: begin
              ctl.res_en     = 1'b1;
              ctl.res_status = ST_OK;
              ctl.res_val    = VAL_HOLD;
              state_next     = S_IDLE;
            end
            CMD_DELETE: begin
              ctl.cnt_op     = CNT_DEC;
              ctl.res_en     = 1'b1;
              ctl.res_status = ST_OK;
              ctl.res_val    = VAL_HOLD;
              state_next     = S_IDLE;
            end
            CMD_INSERT: begin
              ctl.wr_en      = 1'b1;
              ctl.wr_src     = SRC_VALUE;
              wr_addr        = pos_r;
              ctl.cnt_op     = CNT_INC;
              ctl.res_en     = 1'b1;
              ctl.res_status = ST_OK;
              state_next     = S_IDLE;
            end
            CMD_SORT: begin
              // The largest value of this pass lands at the end of the unsorted part.
              ctl.wr_en  = 1'b1;
              ctl.wr_src = SRC_HOLD;
              wr_addr    = AW'(slen - CW'(1));
              if (slen > CW'(2)) begin
                slen_next  = slen - CW'(1);
                rem_next   = slen - CW'(1);
                idx_next   = '0;
                first_next = 1'b1;
              end else begin
                ctl.res_en     = 1'b1;
                ctl.res_status = ST_OK;
                state_next     = S_IDLE;
              end
            end
            default: begin
              ctl.res_en     = 1'b1;
              ctl.res_status = ST_INVALID;
              state_next     = S_IDLE;
            end
          endcase
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pv     <= 1'b0;
      pfirst <= 1'b0;
      first  <= 1'b0;
      rem    <= '0;
    end else begin
      state  <= state_next;
      pv     <= pv_next;
      pfirst <= pfirst_next;
      first  <= first_next;
      rem    <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    op    <= op_next;
    idx   <= idx_next;
    paddr <= paddr_next;
    pos_r <= pos_r_next;
    slen  <= slen_next;
  end

endmodule

`default_nettype wire

FILE: verif/positional_list_with_sort_tb.sv
// Self-checking testbench for the positional list with in-place sort.
`timescale 1ns / 1ps

module positional_list_with_sort_tb;
  import pls_pkg::*;

  localparam int LIST_DEPTH = DEF_CAPACITY;
  localparam int ITEM_TARGET = 1050;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic [1:0]              cmd;
    logic [POS_W-1:0]        pos;
    logic signed [DATA_W-1:0] val;
    bit                      drain;
  } list_cmd_t;

  typedef struct {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] val;
    logic [COUNT_W-1:0]       cnt;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] cmd = CMD_READ;
  logic [POS_W-1:0] position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic busy;
  logic done;
  logic [1:0] status;
  logic signed [DATA_W-1:0] value_out;
  logic [COUNT_W-1:0] count;

  // Predictor state: the list contents and its length.
  logic signed [DATA_W-1:0] list_model [LIST_DEPTH];
  int list_len = 0;

  list_cmd_t pending_cmds[$];
  list_result_t expected_results[$];
  list_cmd_t cur_cmd;
  int mismatches = 0;
  int gen_len = 0;
  int gen_total = 0;
  int accepted = 0;
  int gap_left = 0;
  bit drive_next;

  positional_list_with_sort #(.CAPACITY(LIST_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .position(position),
    .value(value),
    .done(done),
    .status(status),
    .value_out(value_out),
    .count(count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic list_result_t apply_list_cmd(list_cmd_t c);
    list_result_t r;
    int k;
    int pass;
    logic signed [DATA_W-1:0] t;
    r.status = ST_OK;
    r.val = '0;
    case (c.cmd)
      CMD_INSERT: begin
        if (c.pos < 1 || c.pos > list_len + 1) begin
          r.status = ST_INVALID;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (k = list_len; k > c.pos - 1; k--) list_model[k] = list_model[k-1];
          list_model[c.pos-1] = c.val;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (list_len == 0 || c.pos < 1 || c.pos > list_len) begin
          r.status = ST_INVALID;
        end else begin
          r.val = list_model[c.pos-1];
          for (k = c.pos - 1; k + 1 < list_len; k++) list_model[k] = list_model[k+1];
          list_len--;
        end
      end
      CMD_SORT: begin
        if (list_len == 0) begin
          r.status = ST_INVALID;
        end else begin
          for (pass = 0; pass + 1 < list_len; pass++) begin
            for (k = 0; k + 1 < list_len - pass; k++) begin
              if (list_model[k] > list_model[k+1]) begin
                t = list_model[k];
                list_model[k] = list_model[k+1];
                list_model[k+1] = t;
              end
            end
          end
        end
      end
      default: begin
        if (list_len == 0 || c.pos < 1 || c.pos > list_len) r.status = ST_INVALID;
        else r.val = list_model[c.pos-1];
      end
    endcase
    r.cnt = list_len[COUNT_W-1:0];
    return r;
  endfunction

  // Queues an item and tracks the list length the generator expects.
  task automatic add_item(input logic [1:0] c, input int p, input logic [DATA_W-1:0] v,
                          input bit drain);
    list_cmd_t it;
    it.cmd = c;
    it.pos = p[POS_W-1:0];
    it.val = v;
    it.drain = drain;
    pending_cmds.push_back(it);
    gen_total++;
    if (c == CMD_INSERT && p >= 1 && p <= gen_len + 1 && gen_len < LIST_DEPTH) gen_len++;
    if (c == CMD_DELETE && p >= 1 && p <= gen_len) gen_len--;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 8) - 4;
      3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_pos(input logic [1:0] c);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
    if (c == CMD_INSERT) return $urandom_range(1, gen_len + 1);
    if (gen_len == 0) return $urandom_range(0, 3);
    return $urandom_range(1, gen_len);
  endfunction

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected %0h actual %0h", $realtime, what, exp_v, act_v);
  endtask

  // Driver: presents the next pending item and predicts it when accepted.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      drive_next = start;
      if (start && !busy) begin
        expected_results.push_back(apply_list_cmd(cur_cmd));
        accepted++;
        drive_next = 1'b0;
        // Idling only in some stretches, and never near the end of the run.
        if (pending_cmds.size() > 100 && (accepted / 100) % 3 != 2 &&
            $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 6);
      end
      if (!drive_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain && expected_results.size() != 0)) begin
          cur_cmd = pending_cmds.pop_front();
          cmd <= cur_cmd.cmd;
          position <= cur_cmd.pos;
          value <= cur_cmd.val;
          drive_next = 1'b1;
        end
      end
      start <= drive_next;
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result, status", '0, DATA_W'(status));
      end else begin
        exp_r = expected_results.pop_front();
        if (status !== exp_r.status)
          note_mismatch("status", DATA_W'(exp_r.status), DATA_W'(status));
        if (value_out !== exp_r.val) note_mismatch("value_out", exp_r.val, value_out);
        if (count !== exp_r.cnt)
          note_mismatch("count", DATA_W'(exp_r.cnt), DATA_W'(count));
      end
    end
  end

  initial begin
    int mode;
    int r;
    logic [1:0] c;
    // Empty and small list corner cases.
    add_item(CMD_READ, 1, 32'h1234_5678, 1'b0);
    add_item(CMD_DELETE, 1, 32'h0, 1'b0);
    add_item(CMD_SORT, 1, 32'h0, 1'b0);
    add_item(CMD_INSERT, 0, 32'h5, 1'b0);
    add_item(CMD_INSERT, 2, 32'h6, 1'b0);
    add_item(CMD_INSERT, 1, 32'h7fff_ffff, 1'b0);
    add_item(CMD_SORT, 0, 32'h0, 1'b0);
    add_item(CMD_READ, 0, 32'h0, 1'b0);
    add_item(CMD_READ, 2, 32'h0, 1'b0);
    add_item(CMD_INSERT, 1, 32'h8000_0000, 1'b0);
    add_item(CMD_INSERT, 3, 32'hffff_ffff, 1'b0);
    add_item(CMD_INSERT, 2, 32'h1, 1'b0);
    add_item(CMD_READ, 1, 32'h0, 1'b0);
    add_item(CMD_READ, 4, 32'h0, 1'b0);
    add_item(CMD_SORT, 127, 32'hffff_ffff, 1'b0);
    add_item(CMD_READ, 1, 32'h0, 1'b0);
    add_item(CMD_READ, 4, 32'h0, 1'b0);
    add_item(CMD_READ, 5, 32'h0, 1'b0);
    add_item(CMD_DELETE, 4, 32'h0, 1'b0);
    add_item(CMD_DELETE, 1, 32'h0, 1'b0);
    add_item(CMD_DELETE, 3, 32'h0, 1'b0);
    add_item(CMD_DELETE, 127, 32'h0, 1'b0);
    add_item(CMD_INSERT, 127, 32'h0, 1'b0);
    // Fill to capacity, then hit the full list with valid and invalid positions.
    while (gen_len < LIST_DEPTH)
      add_item(CMD_INSERT, $urandom_range(1, gen_len + 1), pick_value(), gen_total == 30);
    add_item(CMD_INSERT, $urandom_range(1, LIST_DEPTH + 1), pick_value(), 1'b0);
    add_item(CMD_INSERT, LIST_DEPTH + 2, pick_value(), 1'b0);
    add_item(CMD_SORT, 0, 32'h0, 1'b0);
    add_item(CMD_READ, 1, 32'h0, 1'b0);
    add_item(CMD_READ, LIST_DEPTH, 32'h0, 1'b0);
    mode = 0;
    while (gen_total < ITEM_TARGET) begin
      if (gen_total % 40 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      case (mode)
        0: c = r < 65 ? CMD_INSERT : r < 75 ? CMD_DELETE : r < 83 ? CMD_SORT : CMD_READ;
        1: c = r < 20 ? CMD_INSERT : r < 70 ? CMD_DELETE : r < 78 ? CMD_SORT : CMD_READ;
        default: c = r < 35 ? CMD_INSERT : r < 60 ? CMD_DELETE : r < 70 ? CMD_SORT : CMD_READ;
      endcase
      add_item(c, pick_pos(c), pick_value(), gen_total % 250 == 0);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: positional_list_with_sort.f
hw/rtl/pls_pkg.sv
hw/rtl/pls_ram.sv
hw/rtl/pls_dp.sv
hw/rtl/pls_ctrl.sv
hw/rtl/positional_list_with_sort.sv
verif/positional_list_with_sort_tb.sv
